FILE: rtl/cdfs_pkg.sv
`default_nettype none
package cdfs_pkg;
    localparam int MAX_WIDTH_D  = 256;
    localparam int MAX_HEIGHT_D = 128;
    localparam int FRAC_BITS_D  = 24;

    localparam logic [1:0] OP_WR_MARG = 2'd0;
    localparam logic [1:0] OP_WR_COND = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] table_index;
        logic [24:0] cdf_value;
        logic [23:0] sample_x;
        logic [23:0] sample_y;
    } t_req;

    typedef struct packed {
        logic [23:0] coord_u;
        logic [23:0] coord_v;
        logic [7:0]  texel_column;
        logic [6:0]  texel_row;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRITE, ST_SRCH, ST_SRCH_W, ST_LO, ST_LO_W, ST_HI_W,
        ST_DIV1, ST_DIV1_W, ST_DIV2, ST_DIV2_W, ST_NEXT, ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;     // capture request
        logic       wr;       // perform table write
        logic       pass;     // 0 row, 1 column
        logic       srch_init;
        logic       probe_rd; // issue probe read
        logic       probe_upd;
        logic       lo_rd;
        logic       lo_cap;
        logic       hi_rd;
        logic       hi_cap;
        logic       div1_go;
        logic       div2_go;
        logic       coord_cap;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic srch_done;
        logic div_busy;
    } t_sts;
endpackage
`default_nettype wire

FILE: rtl/cdf_table_2d_sampler_top.sv
`default_nettype none
// Two-dimensional piecewise-constant CDF sampler. Load the marginal CDF (op 0)
// and the conditional CDFs (op 1, index row*(width+1)+column) entry by entry,
// then send op 2 requests with two Q0.24 fractions; each returns the texel and
// the continuous UV. A sample runs two passes (row, then column), each a
// binary search of floor(log2(n))+1 probes (read, then update) on the table's
// single read port plus a check for the search end, a fetch of the two cell
// bounds, two 49-step bit-serial divisions (remap, coordinate) on one shared
// divider, and a hand-over to the output register.
// One request is in work at a time; a finished result waits in the output
// register.
module cdf_table_2d_sampler_top
    import cdfs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_D,
    parameter int MAX_HEIGHT = MAX_HEIGHT_D,
    parameter int FRAC_BITS  = FRAC_BITS_D
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_req        i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_rsp             o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [8:0] r_width;
    logic [7:0] r_height;
    logic       r_out_valid;
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic       w_wr;

    // hold register writes until the access phase; clamp to the legal range
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'(MAX_WIDTH);
            r_height <= 8'(MAX_HEIGHT);
        end else if (w_wr) begin
            if (paddr[2] == REG_HEIGHT[0]) begin
                if (pwdata[7:0] == 8'd0) r_height <= 8'd1;
                else if (32'(pwdata[7:0]) > MAX_HEIGHT) r_height <= 8'(MAX_HEIGHT);
                else r_height <= pwdata[7:0];
            end else if (paddr[2] == REG_WIDTH[0]) begin
                if (pwdata[8:0] == 9'd0) r_width <= 9'd1;
                else if (32'(pwdata[8:0]) > MAX_WIDTH) r_width <= 9'(MAX_WIDTH);
                else r_width <= pwdata[8:0];
            end
        end
    end
    assign prdata = paddr[2] ? 32'(r_height) : 32'(r_width);

    cdfs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_req(i_in_data), .i_out_full(r_out_valid && i_out_stall),
        .i_sts(w_sts), .o_in_stall(o_in_stall), .o_cmd(w_cmd)
    );

    cdfs_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
              .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_in_data), .i_cmd(w_cmd),
        .i_width(r_width), .i_height(r_height), .o_sts(w_sts), .o_rsp(o_out_data)
    );

    // output register: advance on load, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_cmd.out_load) r_out_valid <= 1'b1;
        else if (!i_out_stall) r_out_valid <= 1'b0;
    end
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result overwrote a pending one");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_busy |-> o_in_stall)
        else $error("request accepted during division");
`endif
endmodule
`default_nettype wire

FILE: rtl/cdfs_div.sv
`default_nettype none
module cdfs_div
    import cdfs_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 25
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic [NW-1:0]      o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   w_sh;

    // shift one bit of the numerator per cycle
    always_comb begin
        w_sh  = {r_rem[DW-1:0], r_q[NW-1]};
        n_q   = {r_q[NW-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_go) begin
            r_cnt <= CW'(NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
endmodule
`default_nettype wire

FILE: rtl/cdfs_ctrl.sv
`default_nettype none
module cdfs_ctrl
    import cdfs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_req  i_req,
    input  wire logic  i_out_full,
    input  wire t_sts  i_sts,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        o_cmd      = '0;
        o_cmd.pass = r_pass;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_req.op == OP_SAMPLE) begin
                        n_state = ST_SRCH;
                        n_pass  = 1'b0;
                        o_cmd.pass = 1'b0;
                        o_cmd.srch_init = 1'b1;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_SRCH: begin
                if (i_sts.srch_done) begin
                    n_state = ST_LO;
                end else begin
                    o_cmd.probe_rd = 1'b1;
                    n_state = ST_SRCH_W;
                end
            end
            ST_SRCH_W: begin
                o_cmd.probe_upd = 1'b1;
                n_state = ST_SRCH;
            end
            ST_LO: begin
                o_cmd.lo_rd = 1'b1;
                n_state = ST_LO_W;
            end
            ST_LO_W: begin
                o_cmd.lo_cap = 1'b1;
                o_cmd.hi_rd  = 1'b1;
                n_state = ST_HI_W;
            end
            ST_HI_W: begin
                o_cmd.hi_cap = 1'b1;
                n_state = ST_DIV1;
            end
            ST_DIV1: begin
                o_cmd.div1_go = 1'b1;
                n_state = ST_DIV1_W;
            end
            ST_DIV1_W: begin
                if (!i_sts.div_busy) n_state = ST_DIV2;
            end
            ST_DIV2: begin
                o_cmd.div2_go = 1'b1;
                n_state = ST_DIV2_W;
            end
            ST_DIV2_W: begin
                if (!i_sts.div_busy) begin
                    o_cmd.coord_cap = 1'b1;
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (!r_pass) begin
                    n_pass = 1'b1;
                    o_cmd.pass = 1'b1;
                    o_cmd.srch_init = 1'b1;
                    n_state = ST_SRCH;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/cdfs_dp.sv
`default_nettype none
module cdfs_dp
    import cdfs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_D,
    parameter int MAX_HEIGHT = MAX_HEIGHT_D,
    parameter int FRAC_BITS  = FRAC_BITS_D
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_req  i_req,
    input  wire t_cmd  i_cmd,
    input  wire logic [8:0] i_width,
    input  wire logic [7:0] i_height,
    output t_sts       o_sts,
    output t_rsp       o_rsp
);
    localparam int MDEP = MAX_HEIGHT + 1;
    localparam int CDEP = MAX_HEIGHT * (MAX_WIDTH + 1);
    localparam int MAW  = $clog2(MDEP);
    localparam int CAW  = $clog2(CDEP);
    localparam int NW   = FRAC_BITS + 25;

    logic [24:0] r_marg [MDEP];
    logic [24:0] r_cond [CDEP];
    logic [24:0] r_mrd, r_crd;

    t_req r_req;
    logic [12:0] r_first, r_count;
    logic [12:0] w_step, w_probe, w_cell, w_n;
    logic [23:0] w_s;
    logic [24:0] w_rd;
    logic [24:0] r_c0, r_c1;
    logic [12:0] r_cell;
    logic [7:0]  r_col;
    logic [6:0]  r_row;
    logic [23:0] r_cu, r_cv;
    logic [CAW-1:0] r_rowbase;
    logic [15:0] w_addr;
    logic [24:0] w_rmp;
    logic [NW-1:0] w_num, w_quo;
    logic [24:0] w_den, w_diff, w_sdiff;
    logic w_go, w_busy, w_rd_en;
    t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
    end

    // table writes, one read port each; read data is valid the cycle after the address
    assign w_rd_en = i_cmd.probe_rd || i_cmd.lo_rd || i_cmd.hi_rd;
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && r_req.op == OP_WR_MARG && 32'(r_req.table_index) < MDEP)
            r_marg[r_req.table_index[MAW-1:0]] <= r_req.cdf_value;
        if (w_rd_en) r_mrd <= r_marg[w_addr[MAW-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && r_req.op == OP_WR_COND && 32'(r_req.table_index) < CDEP)
            r_cond[r_req.table_index[CAW-1:0]] <= r_req.cdf_value;
        if (w_rd_en) r_crd <= r_cond[w_addr[CAW-1:0]];
    end

    assign w_n     = i_cmd.pass ? 13'(i_width) : 13'(i_height);
    assign w_s     = i_cmd.pass ? r_req.sample_x : r_req.sample_y;
    assign w_rd    = i_cmd.pass ? r_crd : r_mrd;
    assign w_step  = r_count >> 1;
    assign w_probe = r_first + w_step;
    assign w_cell  = (r_first - 13'd1 > w_n - 13'd1) ? w_n - 13'd1 : r_first - 13'd1;

    always_comb begin
        w_addr = 16'(r_rowbase) + 16'(w_probe);
        if (i_cmd.lo_rd) w_addr = 16'(r_rowbase) + 16'(w_cell);
        if (i_cmd.hi_rd) w_addr = 16'(r_rowbase) + 16'(r_cell) + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_first   <= 13'd1;
            r_count   <= i_cmd.pass ? 13'(i_width) : 13'(i_height);
            r_rowbase <= i_cmd.pass ? CAW'(r_row) * CAW'(i_width + 9'd1) : '0;
        end else if (i_cmd.probe_upd) begin
            if (!(25'(w_s) < w_rd)) begin
                r_first <= w_probe + 13'd1;
                r_count <= r_count - w_step - 13'd1;
            end else begin
                r_count <= w_step;
            end
        end
        if (i_cmd.lo_rd) r_cell <= w_cell;
        if (i_cmd.lo_cap) r_c0 <= w_rd;
        if (i_cmd.hi_cap) r_c1 <= w_rd;
    end

    // remap, then coordinate, on one shared divider
    assign w_diff  = r_c1 - r_c0;
    assign w_sdiff = (25'(w_s) > r_c0) ? 25'(w_s) - r_c0 : 25'd0;
    assign w_rmp   = (r_c1 <= r_c0) ? 25'd0 : w_quo[24:0];
    always_comb begin
        if (i_cmd.div2_go) begin
            w_num = (NW'(r_cell) << FRAC_BITS) + NW'(w_rmp);
            w_den = i_cmd.pass ? 25'(i_width) : 25'(i_height);
        end else begin
            w_num = NW'((w_sdiff > w_diff) ? w_diff : w_sdiff) << FRAC_BITS;
            w_den = w_diff;
        end
    end
    assign w_go = i_cmd.div1_go || i_cmd.div2_go;

    cdfs_div #(.NW(NW), .DW(25)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_go), .i_num(w_num),
        .i_den(w_den), .o_busy(w_busy), .o_quo(w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.coord_cap) begin
            if (i_cmd.pass) begin
                r_col <= r_cell[7:0];
                r_cu  <= (w_quo > NW'(24'hFFFFFF)) ? 24'hFFFFFF : w_quo[23:0];
            end else begin
                r_row <= r_cell[6:0];
                r_cv  <= (w_quo > NW'(24'hFFFFFF)) ? 24'hFFFFFF : w_quo[23:0];
            end
        end
        if (i_cmd.out_load) r_rsp <= '{r_cu, r_cv, r_col, r_row};
    end

    assign o_sts.srch_done = (r_count == 13'd0);
    assign o_sts.div_busy  = w_busy;
    assign o_rsp = r_rsp;
endmodule
`default_nettype wire
